@@ rtl/core/mpsm_pkg.sv @@
// Shared result codes and the control bundle between the sequencer and the result stage.
`default_nettype none
package mpsm_pkg;

   localparam logic [2:0] KIND_LOAD_DONE = 3'd0;
   localparam logic [2:0] KIND_MATCH     = 3'd1;
   localparam logic [2:0] KIND_NO_MATCH  = 3'd2;
   localparam logic [2:0] KIND_BAD       = 3'd3;
   localparam logic [2:0] KIND_DROPPED   = 3'd4;

   localparam logic       CMD_LOAD       = 1'b0;
   localparam logic       CMD_SEARCH     = 1'b1;

   localparam logic [7:0] FIRST_CHAR     = 8'd32;
   localparam int         MAX_RESULTS    = 64;

   typedef struct packed {
      logic        start_run;
      logic        push;
      logic        finish;
      logic        single;
      logic [2:0]  kind;
      logic [7:0]  id;
      logic [15:0] start;
   } emit_ctl_type;

endpackage
`default_nettype wire

@@ rtl/core/mpsm_emit.sv @@
// Result stage: holds one match back to mark the end of a run and to cap the result count.
`default_nettype none
module mpsm_emit
   import mpsm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire emit_ctl_type ctl,
   output logic              stopped,
   output logic              rsp_valid,
   output logic [2:0]        rsp_kind,
   output logic [7:0]        rsp_match_id,
   output logic [15:0]       rsp_start_pos,
   output logic              rsp_end_of_run
);

   logic        pend_ff, pend_in;
   logic [7:0]  pid_ff, pid_in;
   logic [15:0] pst_ff, pst_in;
   logic [5:0]  n_ff, n_in;
   logic        stop_ff, stop_in;
   logic        v_ff, v_in;
   logic [2:0]  kind_ff, kind_in;
   logic [7:0]  id_ff, id_in;
   logic [15:0] st_ff, st_in;
   logic        end_ff, end_in;

   always_comb begin
      pend_in = pend_ff;
      pid_in  = pid_ff;
      pst_in  = pst_ff;
      n_in    = n_ff;
      stop_in = stop_ff;
      v_in    = 1'b0;
      kind_in = kind_ff;
      id_in   = 8'd0;
      st_in   = 16'd0;
      end_in  = 1'b0;
      if (ctl.start_run) begin
         pend_in = 1'b0;
         n_in    = 6'd0;
         stop_in = 1'b0;
      end else if (ctl.single) begin
         v_in    = 1'b1;
         kind_in = ctl.kind;
         end_in  = 1'b1;
      end else if (ctl.push && !stop_ff) begin
         if (pend_ff) begin
            v_in = 1'b1;
            if (n_ff == 6'(MAX_RESULTS - 1)) begin
               // Another match exists beyond the last free slot.
               kind_in = KIND_DROPPED;
               end_in  = 1'b1;
               stop_in = 1'b1;
            end else begin
               kind_in = KIND_MATCH;
               id_in   = pid_ff;
               st_in   = pst_ff;
               n_in    = n_ff + 6'd1;
            end
         end
         pend_in = 1'b1;
         pid_in  = ctl.id;
         pst_in  = ctl.start;
      end else if (ctl.finish && !stop_ff) begin
         v_in   = 1'b1;
         end_in = 1'b1;
         if (pend_ff) begin
            kind_in = KIND_MATCH;
            id_in   = pid_ff;
            st_in   = pst_ff;
         end else begin
            kind_in = KIND_NO_MATCH;
         end
         pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         n_ff    <= 6'd0;
         stop_ff <= 1'b0;
         v_ff    <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         n_ff    <= n_in;
         stop_ff <= stop_in;
         v_ff    <= v_in;
      end
      pid_ff  <= pid_in;
      pst_ff  <= pst_in;
      kind_ff <= kind_in;
      id_ff   <= id_in;
      st_ff   <= st_in;
      end_ff  <= end_in;
   end

   assign stopped        = stop_ff;
   assign rsp_valid      = v_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_match_id   = id_ff;
   assign rsp_start_pos  = st_ff;
   assign rsp_end_of_run = end_ff;

`ifndef SYNTHESIS
   a_drop_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_DROPPED |-> rsp_end_of_run)
      else $error("dropped marker without end of run");
   a_stop_quiet: assert property (@(posedge clock) disable iff (reset)
      stop_ff && !ctl.start_run && !ctl.single |=> !rsp_valid)
      else $error("result after run was capped");
   a_nomatch_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_NO_MATCH |-> rsp_end_of_run)
      else $error("no-match result without end of run");
`endif

endmodule
`default_nettype wire

@@ rtl/core/multi_pattern_string_matcher_top.sv @@
// Aho-Corasick matcher: trie load, breadth-first link rebuild and text search over memories.
// A text item after a trie change first rebuilds the links over every (node, symbol) pair
// of each queued node, then walks the output-link chain and reports each id in turn.
// Items are taken one at a time; results are strobed and cannot be stalled. Reset clears
// control state at once, then a clearing pass over every row empties the child table.
`default_nettype none
module multi_pattern_string_matcher_top
   import mpsm_pkg::*;
#(
   parameter int ALPHABET_SIZE = 96,
   parameter int MAX_NODES     = 1024,
   parameter int MAX_PATTERNS  = 256,
   parameter int IDS_PER_NODE  = 4,
   parameter int POS_BITS      = 16
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_cmd,
   input  wire logic [7:0]  req_ch,
   input  wire logic [7:0]  req_pattern_id,
   input  wire logic        req_last,
   input  wire logic        req_first,
   output logic             rsp_valid,
   output logic [2:0]       rsp_kind,
   output logic [7:0]       rsp_match_id,
   output logic [15:0]      rsp_start_pos,
   output logic             rsp_end_of_run
);

   localparam int NW   = $clog2(MAX_NODES);
   localparam int SYW  = $clog2(ALPHABET_SIZE);
   localparam int AD   = MAX_NODES * ALPHABET_SIZE;
   localparam int AW   = $clog2(AD);
   localparam int ID_D = MAX_NODES * IDS_PER_NODE;
   localparam int IW   = $clog2(ID_D);
   localparam int ICW  = $clog2(IDS_PER_NODE + 1);
   localparam int CW0  = (POS_BITS > NW) ? POS_BITS : NW;
   localparam int CW   = (CW0 > 16) ? CW0 : 16;

   typedef enum logic [18:0] {
      S_CLEAR   = 19'b0000000000000000001,
      S_IDLE    = 19'b0000000000000000010,
      S_ONE     = 19'b0000000000000000100,
      S_LD_W    = 19'b0000000000000001000,
      S_LD_DO   = 19'b0000000000000010000,
      S_RB_INIT = 19'b0000000000000100000,
      S_RB_RD   = 19'b0000000000001000000,
      S_RB_EV   = 19'b0000000000010000000,
      S_RB_OUT  = 19'b0000000000100000000,
      S_RB_POP  = 19'b0000000001000000000,
      S_RB_U    = 19'b0000000010000000000,
      S_RB_F    = 19'b0000000100000000000,
      S_SR_RD   = 19'b0000001000000000000,
      S_SR_NX   = 19'b0000010000000000000,
      S_WK_RD   = 19'b0000100000000000000,
      S_WK_EV   = 19'b0001000000000000000,
      S_WK_ID   = 19'b0010000000000000000,
      S_WK_PUSH = 19'b0100000000000000000,
      S_FIN     = 19'b1000000000000000000
   } state_type;

   function automatic logic [AW-1:0] row_addr(input logic [NW-1:0] u, input logic [SYW-1:0] c);
      return AW'(u) * AW'(ALPHABET_SIZE) + AW'(c);
   endfunction

   // Node memories. Each has one write port and one registered read port.
   logic [NW-1:0]  child_mem [AD];
   logic [NW-1:0]  tc_mem    [AD];
   logic [NW-1:0]  fail_mem  [MAX_NODES];
   logic [NW-1:0]  outl_mem  [MAX_NODES];
   logic           term_mem  [MAX_NODES];
   logic [ICW-1:0] cnt_mem   [MAX_NODES];
   logic [NW-1:0]  len_mem   [MAX_NODES];
   logic [7:0]     ids_mem   [ID_D];
   logic [NW-1:0]  q_mem     [MAX_NODES];

   logic           ch_we, tc_we, fl_we, ol_we, tm_we, cn_we, ln_we, id_we, q_we;
   logic [AW-1:0]  ch_wa, ch_ra, tc_wa, tc_ra;
   logic [NW-1:0]  fl_wa, fl_ra, ol_wa, ol_ra, tm_wa, tm_ra, cn_wa, cn_ra;
   logic [NW-1:0]  ln_wa, ln_ra, q_wa, q_ra;
   logic [IW-1:0]  id_wa, id_ra;
   logic [NW-1:0]  ch_wd, tc_wd, fl_wd, ol_wd, ln_wd, q_wd;
   logic           tm_wd;
   logic [ICW-1:0] cn_wd;
   logic [7:0]     id_wd;
   logic [NW-1:0]  ch_rd_ff, tc_rd_ff, fl_rd_ff, ol_rd_ff, ln_rd_ff, q_rd_ff;
   logic           tm_rd_ff;
   logic [ICW-1:0] cn_rd_ff;
   logic [7:0]     id_rd_ff;

   always_ff @(posedge clock) begin
      if (ch_we) child_mem[ch_wa] <= ch_wd;
      ch_rd_ff <= child_mem[ch_ra];
   end
   always_ff @(posedge clock) begin
      if (tc_we) tc_mem[tc_wa] <= tc_wd;
      tc_rd_ff <= tc_mem[tc_ra];
   end
   always_ff @(posedge clock) begin
      if (fl_we) fail_mem[fl_wa] <= fl_wd;
      fl_rd_ff <= fail_mem[fl_ra];
   end
   always_ff @(posedge clock) begin
      if (ol_we) outl_mem[ol_wa] <= ol_wd;
      ol_rd_ff <= outl_mem[ol_ra];
   end
   always_ff @(posedge clock) begin
      if (tm_we) term_mem[tm_wa] <= tm_wd;
      tm_rd_ff <= term_mem[tm_ra];
   end
   always_ff @(posedge clock) begin
      if (cn_we) cnt_mem[cn_wa] <= cn_wd;
      cn_rd_ff <= cnt_mem[cn_ra];
   end
   always_ff @(posedge clock) begin
      if (ln_we) len_mem[ln_wa] <= ln_wd;
      ln_rd_ff <= len_mem[ln_ra];
   end
   always_ff @(posedge clock) begin
      if (id_we) ids_mem[id_wa] <= id_wd;
      id_rd_ff <= ids_mem[id_ra];
   end
   always_ff @(posedge clock) begin
      if (q_we) q_mem[q_wa] <= q_wd;
      q_rd_ff <= q_mem[q_ra];
   end

   // Sequencer registers.
   state_type         state_ff, state_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [NW-1:0]     lnode_ff, lnode_in;
   logic [NW-1:0]     depth_ff, depth_in;
   logic [NW:0]       ncount_ff, ncount_in;
   logic              stale_ff, stale_in;
   logic [NW-1:0]     snode_ff, snode_in;
   logic [POS_BITS-1:0] pos_ff, pos_in;
   logic [NW-1:0]     head_ff, head_in, tail_ff, tail_in;
   logic [SYW-1:0]    sym_ff, sym_in;
   logic              last_ff, last_in;
   logic [7:0]        pid_ff, pid_in;
   logic [2:0]        kind_ff, kind_in;
   logic [NW-1:0]     w_ff, w_in, g_ff, g_in, u_ff, u_in, f_ff, f_in;
   logic              root_ff, root_in;
   logic [SYW-1:0]    c_ff, c_in;
   logic [NW-1:0]     k_ff, k_in, nk_ff, nk_in, len_ff, len_in;
   logic [ICW-1:0]    idn_ff, idn_in, i_ff, i_in;

   logic              accept;
   logic [7:0]        chm;
   logic              ch_ok;
   logic [SYW-1:0]    req_sym;
   logic              stopped;
   emit_ctl_type      ectl;

   // Decision terms for a load step, the link rebuild and the match start position.
   logic              ld_new, ld_bad;
   logic [NW-1:0]     ld_node;
   logic [ICW-1:0]    ld_cnt;
   logic [NW-1:0]     rb_g;
   logic [CW-1:0]     pos_x, len_x, st_x;
   logic              sym_end;

   assign accept  = start && !busy;
   assign busy    = (state_ff != S_IDLE);
   assign chm     = req_ch - FIRST_CHAR;
   assign ch_ok   = (req_ch >= FIRST_CHAR) && ({1'b0, chm} < 9'(ALPHABET_SIZE));
   assign req_sym = chm[SYW-1:0];

   // The child read is registered into w_ff in S_LD_W; the decision is taken from it in S_LD_DO.
   assign ld_new  = (w_ff == '0);
   assign ld_node = ld_new ? ncount_ff[NW-1:0] : w_ff;
   assign ld_cnt  = ld_new ? '0 : cn_rd_ff;
   assign ld_bad  = (ld_new && ncount_ff >= (NW+1)'(MAX_NODES))
                 || (last_ff && ((32'(pid_ff) >= 32'(MAX_PATTERNS))
                 || (!ld_new && cn_rd_ff >= ICW'(IDS_PER_NODE))));
   assign rb_g    = root_ff ? '0 : tc_rd_ff;
   assign sym_end = (c_ff == SYW'(ALPHABET_SIZE - 1));

   // Zero-based start of a match, clamped at zero.
   assign pos_x = CW'(pos_ff);
   assign len_x = CW'(len_ff);
   assign st_x  = (pos_x >= len_x) ? pos_x - len_x : '0;

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      lnode_in  = lnode_ff;
      depth_in  = depth_ff;
      ncount_in = ncount_ff;
      stale_in  = stale_ff;
      snode_in  = snode_ff;
      pos_in    = pos_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      sym_in    = sym_ff;
      last_in   = last_ff;
      pid_in    = pid_ff;
      kind_in   = kind_ff;
      w_in      = w_ff;
      g_in      = g_ff;
      u_in      = u_ff;
      f_in      = f_ff;
      root_in   = root_ff;
      c_in      = c_ff;
      k_in      = k_ff;
      nk_in     = nk_ff;
      len_in    = len_ff;
      idn_in    = idn_ff;
      i_in      = i_ff;

      ch_we = 1'b0; ch_wa = '0; ch_wd = '0; ch_ra = '0;
      tc_we = 1'b0; tc_wa = '0; tc_wd = '0; tc_ra = '0;
      fl_we = 1'b0; fl_wa = '0; fl_wd = '0; fl_ra = '0;
      ol_we = 1'b0; ol_wa = '0; ol_wd = '0; ol_ra = '0;
      tm_we = 1'b0; tm_wa = '0; tm_wd = 1'b0; tm_ra = '0;
      cn_we = 1'b0; cn_wa = '0; cn_wd = '0; cn_ra = '0;
      ln_we = 1'b0; ln_wa = '0; ln_wd = '0; ln_ra = '0;
      id_we = 1'b0; id_wa = '0; id_wd = '0; id_ra = '0;
      q_we  = 1'b0; q_wa  = '0; q_wd  = '0; q_ra  = '0;
      ectl  = '0;

      case (state_ff)
         S_CLEAR: begin
            // Empty the child table; the low rows also clear the flag and id count.
            ch_we = 1'b1;
            ch_wa = clr_ff;
            if (32'(clr_ff) < MAX_NODES) begin
               tm_we = 1'b1;
               tm_wa = clr_ff[NW-1:0];
               cn_we = 1'b1;
               cn_wa = clr_ff[NW-1:0];
            end
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(AD - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            ch_ra = row_addr(lnode_ff, req_sym);
            if (accept) begin
               ectl.start_run = 1'b1;
               sym_in  = req_sym;
               last_in = req_last;
               pid_in  = req_pattern_id;
               kind_in = KIND_BAD;
               if (req_cmd == CMD_LOAD) begin
                  state_in = ch_ok ? S_LD_W : S_ONE;
               end else begin
                  if (req_first) begin
                     snode_in = '0;
                     pos_in   = POS_BITS'(1);
                  end
                  if (!ch_ok) state_in = S_ONE;
                  else if (stale_ff) state_in = S_RB_INIT;
                  else state_in = S_SR_RD;
               end
            end
         end
         S_ONE: begin
            ectl.single = 1'b1;
            ectl.kind   = kind_ff;
            state_in    = S_IDLE;
         end
         S_LD_W: begin
            w_in     = ch_rd_ff;
            cn_ra    = ch_rd_ff;
            state_in = S_LD_DO;
         end
         S_LD_DO: begin
            ectl.single = 1'b1;
            ectl.kind   = ld_bad ? KIND_BAD : KIND_LOAD_DONE;
            state_in    = S_IDLE;
            if (!ld_bad) begin
               if (ld_new) begin
                  ch_we     = 1'b1;
                  ch_wa     = row_addr(lnode_ff, sym_ff);
                  ch_wd     = ld_node;
                  ncount_in = ncount_ff + (NW+1)'(1);
                  stale_in  = 1'b1;
               end
               if (last_ff) begin
                  id_we    = 1'b1;
                  id_wa    = IW'(ld_node) * IW'(IDS_PER_NODE) + IW'(ld_cnt);
                  id_wd    = pid_ff;
                  cn_we    = 1'b1;
                  cn_wa    = ld_node;
                  cn_wd    = ld_cnt + ICW'(1);
                  tm_we    = 1'b1;
                  tm_wa    = ld_node;
                  tm_wd    = 1'b1;
                  ln_we    = 1'b1;
                  ln_wa    = ld_node;
                  ln_wd    = depth_ff + NW'(1);
                  stale_in = 1'b1;
                  lnode_in = '0;
                  depth_in = '0;
               end else begin
                  lnode_in = ld_node;
                  depth_in = depth_ff + NW'(1);
               end
            end
         end
         S_RB_INIT: begin
            fl_we    = 1'b1;
            ol_we    = 1'b1;
            u_in     = '0;
            f_in     = '0;
            root_in  = 1'b1;
            c_in     = '0;
            head_in  = '0;
            tail_in  = '0;
            state_in = S_RB_RD;
         end
         S_RB_RD: begin
            ch_ra    = row_addr(u_ff, c_ff);
            tc_ra    = row_addr(f_ff, c_ff);
            state_in = S_RB_EV;
         end
         S_RB_EV: begin
            tc_we = 1'b1;
            tc_wa = row_addr(u_ff, c_ff);
            if (ch_rd_ff == '0) begin
               // Missing child: inherit the failure node's transition.
               tc_wd = rb_g;
               c_in  = c_ff + SYW'(1);
               state_in = sym_end ? S_RB_POP : S_RB_RD;
            end else begin
               tc_wd    = ch_rd_ff;
               fl_we    = 1'b1;
               fl_wa    = ch_rd_ff;
               fl_wd    = rb_g;
               q_we     = 1'b1;
               q_wa     = tail_ff;
               q_wd     = ch_rd_ff;
               tail_in  = tail_ff + NW'(1);
               w_in     = ch_rd_ff;
               g_in     = rb_g;
               tm_ra    = rb_g;
               ol_ra    = rb_g;
               state_in = S_RB_OUT;
            end
         end
         S_RB_OUT: begin
            ol_we = 1'b1;
            ol_wa = w_ff;
            ol_wd = tm_rd_ff ? g_ff : ol_rd_ff;
            c_in  = c_ff + SYW'(1);
            state_in = sym_end ? S_RB_POP : S_RB_RD;
         end
         S_RB_POP: begin
            q_ra = head_ff;
            if (head_ff == tail_ff) begin
               stale_in = 1'b0;
               state_in = S_SR_RD;
            end else begin
               head_in  = head_ff + NW'(1);
               state_in = S_RB_U;
            end
         end
         S_RB_U: begin
            u_in     = q_rd_ff;
            fl_ra    = q_rd_ff;
            state_in = S_RB_F;
         end
         S_RB_F: begin
            f_in     = fl_rd_ff;
            root_in  = 1'b0;
            c_in     = '0;
            state_in = S_RB_RD;
         end
         S_SR_RD: begin
            tc_ra    = row_addr(snode_ff, sym_ff);
            state_in = S_SR_NX;
         end
         S_SR_NX: begin
            snode_in = tc_rd_ff;
            k_in     = tc_rd_ff;
            state_in = (tc_rd_ff == '0) ? S_FIN : S_WK_RD;
         end
         S_WK_RD: begin
            tm_ra    = k_ff;
            cn_ra    = k_ff;
            ln_ra    = k_ff;
            ol_ra    = k_ff;
            state_in = S_WK_EV;
         end
         S_WK_EV: begin
            nk_in  = ol_rd_ff;
            len_in = ln_rd_ff;
            idn_in = cn_rd_ff;
            i_in   = '0;
            if (stopped) begin
               state_in = S_FIN;
            end else if (tm_rd_ff && cn_rd_ff != '0) begin
               state_in = S_WK_ID;
            end else begin
               k_in     = ol_rd_ff;
               state_in = (ol_rd_ff == '0) ? S_FIN : S_WK_RD;
            end
         end
         S_WK_ID: begin
            id_ra    = IW'(k_ff) * IW'(IDS_PER_NODE) + IW'(i_ff);
            state_in = S_WK_PUSH;
         end
         S_WK_PUSH: begin
            ectl.push  = 1'b1;
            ectl.id    = id_rd_ff;
            ectl.start = st_x[15:0];
            i_in       = i_ff + ICW'(1);
            if (stopped) begin
               state_in = S_FIN;
            end else if (i_ff + ICW'(1) == idn_ff) begin
               k_in     = nk_ff;
               state_in = (nk_ff == '0) ? S_FIN : S_WK_RD;
            end else begin
               state_in = S_WK_ID;
            end
         end
         S_FIN: begin
            ectl.finish = 1'b1;
            if (pos_ff != '1) pos_in = pos_ff + POS_BITS'(1);
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         lnode_ff  <= '0;
         depth_ff  <= '0;
         ncount_ff <= (NW+1)'(1);
         stale_ff  <= 1'b1;
         snode_ff  <= '0;
         pos_ff    <= POS_BITS'(1);
         head_ff   <= '0;
         tail_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         lnode_ff  <= lnode_in;
         depth_ff  <= depth_in;
         ncount_ff <= ncount_in;
         stale_ff  <= stale_in;
         snode_ff  <= snode_in;
         pos_ff    <= pos_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
      end
      sym_ff  <= sym_in;
      last_ff <= last_in;
      pid_ff  <= pid_in;
      kind_ff <= kind_in;
      w_ff    <= w_in;
      g_ff    <= g_in;
      u_ff    <= u_in;
      f_ff    <= f_in;
      root_ff <= root_in;
      c_ff    <= c_in;
      k_ff    <= k_in;
      nk_ff   <= nk_in;
      len_ff  <= len_in;
      idn_ff  <= idn_in;
      i_ff    <= i_in;
   end

   mpsm_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ectl),
      .stopped        (stopped),
      .rsp_valid      (rsp_valid),
      .rsp_kind       (rsp_kind),
      .rsp_match_id   (rsp_match_id),
      .rsp_start_pos  (rsp_start_pos),
      .rsp_end_of_run (rsp_end_of_run)
   );

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted item did not raise busy");
   a_search_fresh: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SR_RD |-> !stale_ff)
      else $error("transition read while links stale");
   a_node_bound: assert property (@(posedge clock) disable iff (reset)
      ncount_ff <= (NW+1)'(MAX_NODES))
      else $error("node count beyond table");
`endif

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the Aho-Corasick string matcher: stimulus, prediction and checks.
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
   import mpsm_pkg::*;

   localparam int ALPHA     = 96;
   localparam int NODE_CAP  = 1024;
   localparam int PAT_CAP   = 256;
   localparam int ID_SLOTS  = 4;
   localparam int POS_TOP   = 65535;
   localparam int WDOG_MAX  = 1000000;
   localparam int DRAIN_CYC = 400;

   // The scoreboard keeps its own copy of the automaton. Every accepted transfer on the
   // request side is run through it, and the results it produces wait in order until the
   // block reports them.
   class match_scoreboard;
      typedef struct {
         logic [2:0]  kind;
         logic [7:0]  id;
         logic [15:0] pos;
         logic        eor;
      } match_rsp_type;

      match_rsp_type pending[$];
      int            errors;

      bit [10:0] child[NODE_CAP*ALPHA];
      bit [10:0] trans[NODE_CAP*ALPHA];
      bit [10:0] fail_ln[NODE_CAP];
      bit [10:0] out_ln[NODE_CAP];
      bit        term[NODE_CAP];
      bit [7:0]  node_id[NODE_CAP][ID_SLOTS];
      int        id_cnt[NODE_CAP];
      int        plen[NODE_CAP];
      int        nodes, ld_node, ld_depth, srch_node, text_pos;
      bit        stale;

      function new();
         errors = 0;
         nodes = 1;
         ld_node = 0;
         ld_depth = 0;
         srch_node = 0;
         text_pos = 1;
         stale = 1;
         foreach (child[i]) begin
            child[i] = '0;
            trans[i] = '0;
         end
         foreach (term[i]) begin
            term[i] = 0;
            id_cnt[i] = 0;
            plen[i] = 0;
            fail_ln[i] = '0;
            out_ln[i] = '0;
         end
      endfunction

      // Breadth-first pass that fills in failure links, output links and the full
      // transition table from the trie.
      function void rebuild_links();
         int q[$];
         int u, f, w, g;
         fail_ln[0] = '0;
         out_ln[0] = '0;
         for (int c = 0; c < ALPHA; c++) begin
            w = int'(child[c]);
            trans[c] = 11'(w);
            if (w != 0) begin
               fail_ln[w] = '0;
               out_ln[w] = '0;
               q = {q, w};
            end
         end
         while (q.size() > 0) begin
            u = q.pop_front();
            f = int'(fail_ln[u]);
            for (int c = 0; c < ALPHA; c++) begin
               w = int'(child[u*ALPHA + c]);
               if (w != 0) begin
                  g = int'(trans[f*ALPHA + c]);
                  fail_ln[w] = 11'(g);
                  out_ln[w] = term[g] ? 11'(g) : out_ln[g];
                  trans[u*ALPHA + c] = 11'(w);
                  if (q.size() < NODE_CAP)
                     q = {q, w};
               end else begin
                  trans[u*ALPHA + c] = trans[f*ALPHA + c];
               end
            end
         end
         stale = 0;
      endfunction

      function void note_item(bit cmd, bit [7:0] ch, bit [7:0] pid, bit last, bit first);
         match_rsp_type r;
         match_rsp_type run[$];
         bit            ok_ch;
         int            sym, w, k, st;
         bit            dropped;
         ok_ch = (ch >= FIRST_CHAR) && (ch < FIRST_CHAR + ALPHA);
         sym = ok_ch ? int'(ch - FIRST_CHAR) : 0;
         r = '{KIND_LOAD_DONE, 8'd0, 16'd0, 1'b1};
         if (cmd == CMD_LOAD) begin
            w = ok_ch ? int'(child[ld_node*ALPHA + sym]) : 0;
            if (!ok_ch)
               r.kind = KIND_BAD;
            else if (w == 0 && nodes >= NODE_CAP)
               r.kind = KIND_BAD;
            else if (last && (int'(pid) >= PAT_CAP || (w != 0 && id_cnt[w] >= ID_SLOTS)))
               r.kind = KIND_BAD;
            if (r.kind == KIND_LOAD_DONE) begin
               if (w == 0) begin
                  w = nodes++;
                  child[ld_node*ALPHA + sym] = 11'(w);
                  stale = 1;
               end
               ld_depth++;
               if (last) begin
                  node_id[w][id_cnt[w]] = pid;
                  id_cnt[w]++;
                  term[w] = 1;
                  plen[w] = ld_depth;
                  stale = 1;
                  ld_node = 0;
                  ld_depth = 0;
               end else begin
                  ld_node = w;
               end
            end
            pending = {pending, r};
            return;
         end
         if (first) begin
            srch_node = 0;
            text_pos = 1;
         end
         if (!ok_ch) begin
            r.kind = KIND_BAD;
            pending = {pending, r};
            return;
         end
         if (stale)
            rebuild_links();
         srch_node = int'(trans[srch_node*ALPHA + sym]);
         dropped = 0;
         k = srch_node;
         while (k != 0 && !dropped) begin
            if (term[k]) begin
               for (int i = 0; i < id_cnt[k]; i++) begin
                  st = (text_pos >= plen[k]) ? text_pos - plen[k] : 0;
                  if (run.size() >= MAX_RESULTS) begin
                     dropped = 1;
                     break;
                  end
                  r = '{KIND_MATCH, node_id[k][i], st[15:0], 1'b0};
                  run = {run, r};
               end
            end
            k = int'(out_ln[k]);
         end
         // Past the result limit the last slot is replaced by a drop notice.
         if (dropped)
            run[MAX_RESULTS-1] = '{KIND_DROPPED, 8'd0, 16'd0, 1'b0};
         if (run.size() == 0) begin
            r = '{KIND_NO_MATCH, 8'd0, 16'd0, 1'b0};
            run = {run, r};
         end
         run[run.size()-1].eor = 1'b1;
         pending = {pending, run};
         if (text_pos < POS_TOP)
            text_pos++;
      endfunction

      function void check_result(logic [2:0] kind, logic [7:0] id, logic [15:0] pos,
                                 logic eor);
         match_rsp_type e;
         if (pending.size() == 0) begin
            $error("unexpected result: kind %0d id %0d start %0d", kind, id, pos);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (kind !== e.kind) begin
            $error("kind: expected %0d, actual %0d", e.kind, kind);
            errors++;
         end
         if (id !== e.id) begin
            $error("match_id: expected %0d, actual %0d", e.id, id);
            errors++;
         end
         if (pos !== e.pos) begin
            $error("start_pos: expected %0d, actual %0d", e.pos, pos);
            errors++;
         end
         if (eor !== e.eor) begin
            $error("end_of_run: expected %0d, actual %0d", e.eor, eor);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_cmd;
   logic [7:0]  req_ch;
   logic [7:0]  req_pattern_id;
   logic        req_last;
   logic        req_first;
   logic        rsp_valid;
   logic [2:0]  rsp_kind;
   logic [7:0]  rsp_match_id;
   logic [15:0] rsp_start_pos;
   logic        rsp_end_of_run;

   match_scoreboard sb;
   bit              no_gaps;
   int              idle_cycles;

   multi_pattern_string_matcher_top u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_ch         (req_ch),
      .req_pattern_id (req_pattern_id),
      .req_last       (req_last),
      .req_first      (req_first),
      .rsp_valid      (rsp_valid),
      .rsp_kind       (rsp_kind),
      .rsp_match_id   (rsp_match_id),
      .rsp_start_pos  (rsp_start_pos),
      .rsp_end_of_run (rsp_end_of_run)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Results are strobed for one cycle and cannot be held off, so every cycle with the
   // strobe high is checked at the edge that ends it.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         sb.check_result(rsp_kind, rsp_match_id, rsp_start_pos, rsp_end_of_run);
   end

   // The watchdog counts cycles with no transfer on either side. Its limit covers the
   // clearing pass after reset plus a full link rebuild of the trie sizes used here.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         idle_cycles <= 0;
      else if (idle_cycles >= WDOG_MAX) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // One request transfer. Unless a burst is running, a gap of random length comes first;
   // with no gap, start simply stays high into the next item.
   task automatic send(bit cmd, bit [7:0] ch, bit [7:0] pid, bit last, bit first);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_cmd        <= cmd;
      req_ch         <= ch;
      req_pattern_id <= pid;
      req_last       <= last;
      req_first      <= first;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_item(cmd, ch, pid, last, first);
   endtask

   // Loads a whole pattern; the first flag is ignored on loads, so it carries noise.
   task automatic load_pattern(string s, bit [7:0] pid);
      for (int i = 0; i < s.len(); i++)
         send(CMD_LOAD, s[i], pid, i == s.len() - 1, 1'($urandom_range(0, 1)));
   endtask

   // Searches a text; id and last are ignored on searches and are randomized.
   task automatic search_text(string s, bit restart);
      for (int i = 0; i < s.len(); i++)
         send(CMD_SEARCH, s[i], 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              restart && i == 0);
   endtask

   // Random characters come mostly from a four-letter alphabet so patterns overlap and
   // the failure links get exercised; now and then one of the range extremes.
   function automatic byte pick_char();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0)
         return 8'd32;
      if (r == 1)
         return 8'd127;
      return 8'(97 + $urandom_range(0, 3));
   endfunction

   function automatic string rand_string(int len);
      string s;
      s = "";
      for (int i = 0; i < len; i++)
         s = {s, string'(pick_char())};
      return s;
   endfunction

   initial begin
      bit [7:0] c;
      sb             = new();
      no_gaps        = 0;
      idle_cycles    = 0;
      reset          = 1'b1;
      start          = 1'b0;
      req_cmd        = CMD_LOAD;
      req_ch         = 8'd0;
      req_pattern_id = 8'd0;
      req_last       = 1'b0;
      req_first      = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: the classic overlapping pattern set, the character range edges,
      // the id extremes, a bad character on both commands, an id list that fills up and
      // a duplicate id on one node.
      load_pattern("he", 8'd0);
      load_pattern("she", 8'd255);
      load_pattern("his", 8'd3);
      load_pattern("his", 8'd3);
      send(CMD_LOAD, 8'd31, 8'd9, 1'b1, 1'b0);
      send(CMD_LOAD, 8'd128, 8'd9, 1'b0, 1'b1);
      load_pattern(" ~", 8'd40);
      send(CMD_LOAD, 8'd127, 8'd41, 1'b1, 1'b0);
      load_pattern("he", 8'd5);
      load_pattern("he", 8'd6);
      load_pattern("he", 8'd7);
      // The node for "he" now holds all its ids: this one is refused and the load walk
      // stays on the "h" node, so the following single character extends it.
      load_pattern("he", 8'd8);
      send(CMD_LOAD, 8'd114, 8'd4, 1'b1, 1'b0);
      search_text("ushers", 1'b1);
      send(CMD_SEARCH, 8'd0, 8'd0, 1'b0, 1'b1);
      send(CMD_SEARCH, 8'd255, 8'd0, 1'b1, 1'b0);
      search_text(" ~", 1'b0);
      send(CMD_SEARCH, 8'd127, 8'd0, 1'b0, 1'b0);

      // Random part: rounds of a few new patterns followed by texts over the same
      // alphabet, with bad and arbitrary characters mixed in as noise.
      for (int rnd = 0; rnd < 12; rnd++) begin
         no_gaps = (rnd % 4 == 3);
         repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 9) == 0)
               send(CMD_LOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            load_pattern(rand_string($urandom_range(1, 4)), 8'($urandom_range(0, 255)));
         end
         for (int i = 0, n = $urandom_range(15, 30); i < n; i++) begin
            c = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : pick_char();
            send(CMD_SEARCH, c, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 i == 0 || $urandom_range(0, 40) == 0);
         end
      end
      no_gaps = 0;

      start <= 1'b0;
      while (sb.pending.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
      if (sb.errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire
